// ===== hw/rtl/ikr_pkg.sv =====
package ikr_pkg;

  localparam int LABEL_W   = 6;
  localparam int SIDX_W    = 12;
  localparam int DIDX_W    = 7;
  localparam int VALUE_W   = 16;
  localparam int COMP_W    = 28;
  localparam int CNT_W     = 13;
  localparam int NORM_W    = 38;
  localparam int NORM_LO_W = 19;
  localparam int NSUM_W    = 50;
  localparam int ACC_W     = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int NCLU_CFG_W = 7;
  localparam int NDIM_CFG_W = 8;

  localparam logic [NCLU_CFG_W-1:0] NCLU_RESET = 7'd64;
  localparam logic [NDIM_CFG_W-1:0] NDIM_RESET = 8'd128;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CLUSTERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DIMS     = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_VISIT = 1'b1;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_sts_t;

endpackage

// ===== hw/rtl/ikr_if.sv =====
interface ikr_in_if;
  import ikr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [SIDX_W-1:0]         sample_index;
  logic [DIDX_W-1:0]         dim_index;
  logic signed [VALUE_W-1:0] value;
  logic [LABEL_W-1:0]        initial_label;

  modport source (output valid, opcode, sample_index, dim_index, value, initial_label,
                  input ready);
  modport sink (input valid, opcode, sample_index, dim_index, value, initial_label,
                output ready);
endinterface

interface ikr_out_if;
  import ikr_pkg::*;
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] old_label;
  logic [LABEL_W-1:0] new_label;
  logic               moved;

  modport source (output valid, old_label, new_label, moved, input ready);
  modport sink (input valid, old_label, new_label, moved, output ready);
endinterface

// ===== hw/rtl/ikr_mac.sv =====
module ikr_mac #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ikr_pkg::mac_ctl_t                ctl,
  input  logic signed [ikr_pkg::COMP_W-1:0] a,
  input  logic signed [DATA_WIDTH-1:0]     b,
  output ikr_pkg::mac_sts_t                sts,
  output logic signed [ikr_pkg::ACC_W-1:0] acc
);
  import ikr_pkg::*;

  localparam int PROD_W = COMP_W + DATA_WIDTH;

  logic                     pv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r <= ctl.vld;
      if (ctl.clr) begin
        acc_r <= '0;
      end else if (pv_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    prod_r <= a * b;
  end

  assign sts.busy = pv_r;
  assign acc      = acc_r;
endmodule

// ===== hw/rtl/incremental_kmeans_refine.sv =====
// Incremental k-means refinement over exact integers. A load request writes one
// coordinate of a sample with its starting cluster. A visit request, unless the
// sample's cluster has a single member, costs every active cluster with one
// multiply-accumulate unit fed from the composite and sample memories, then, if another
// cluster costs no more than its own, moves the sample and rewrites both composites; its
// pace is set by that single unit and the one read port of the composite memory. After
// reset the block sweeps the composite, count and norm-sum memories to zero and accepts
// no request until then; configuration writes are taken anytime.
module incremental_kmeans_refine #(
  parameter int MAX_SAMPLES  = 4096,
  parameter int MAX_DIMS     = 128,
  parameter int MAX_CLUSTERS = 64,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ikr_in_if.sink                              in_ch,
  ikr_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [ikr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ikr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ikr_pkg::*;

  localparam int SW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW   = $clog2(MAX_CLUSTERS);
  localparam int SQ_W = 2 * DATA_WIDTH;
  localparam int HI_W = NORM_W - NORM_LO_W;
  localparam int PL_W = CNT_W + NORM_LO_W;
  localparam int PH_W = CNT_W + HI_W;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LD0, S_LD1, S_V0, S_V1, S_V2, S_CL, S_DOT, S_DRAIN, S_CNR,
    S_CN0, S_CN1, S_COST, S_PRF, S_SEL, S_MV0, S_MV1, S_MV2, S_UA, S_UB, S_UC, S_DONE
  } state_t;

  logic signed [COMP_W-1:0]     comp_mem [2**(CW+DW)];
  logic signed [DATA_WIDTH-1:0] smp_mem  [2**(SW+DW)];
  logic [CW-1:0]                lab_mem  [MAX_SAMPLES];
  logic [NORM_W-1:0]            norm_mem [MAX_SAMPLES];
  logic [CNT_W-1:0]             cnt_mem  [2**CW];
  logic [NSUM_W-1:0]            nsum_mem [2**CW];

  logic                         comp_we, smp_we, lab_we, norm_we, cnt_we, nsum_we;
  logic [CW+DW-1:0]             comp_wa, comp_ra;
  logic [SW+DW-1:0]             smp_wa, smp_ra;
  logic [SW-1:0]                lab_wa, lab_ra, norm_wa, norm_ra;
  logic [CW-1:0]                cw_wa, cw_ra;
  logic signed [COMP_W-1:0]     comp_wd, comp_rd;
  logic signed [DATA_WIDTH-1:0] smp_wd, smp_rd;
  logic [CW-1:0]                lab_wd, lab_rd;
  logic [NORM_W-1:0]            norm_wd, norm_rd;
  logic [CNT_W-1:0]             cnt_wd, cnt_rd;
  logic [NSUM_W-1:0]            nsum_wd, nsum_rd;

  state_t                       state_r, state_nxt;
  logic [NCLU_CFG_W-1:0]        ac_r;
  logic [NDIM_CFG_W-1:0]        ad_r;
  logic [CW:0]                  nc;
  logic [DW:0]                  nd;

  logic [SW-1:0]                s_r, s_nxt;
  logic [DIDX_W-1:0]            d_r, d_nxt;
  logic signed [DATA_WIDTH-1:0] v_r, v_nxt;
  logic [CW-1:0]                lab_r, lab_nxt;
  logic [SQ_W-1:0]              sq_r, sq_nxt;
  logic [CW:0]                  c_r, c_nxt;
  logic                         first_r, first_nxt;
  logic [DW:0]                  dcnt_r, dcnt_nxt;
  logic [CW-1:0]                c0_r, c0_nxt, best_r, best_nxt;
  logic                         found_r, found_nxt;
  logic [NORM_W-1:0]            norm_r, norm_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [PL_W-1:0]              pl_r, pl_nxt;
  logic [PH_W-1:0]              ph_r, ph_nxt;
  logic signed [ACC_W-1:0]      t_r, t_nxt, cost_r, cost_nxt, dista_r, dista_nxt;
  logic signed [ACC_W-1:0]      prof_r, prof_nxt, bestp_r, bestp_nxt;
  logic signed [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [CW+DW-1:0]             clr_r, clr_nxt;
  logic                         rvld_r, rvld_nxt;
  logic [CW-1:0]                rold_r, rold_nxt, rnew_r, rnew_nxt;
  logic                         rmv_r, rmv_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0]           out_old_r, out_old_nxt, out_new_r, out_new_nxt;
  logic                         out_mv_r, out_mv_nxt;

  logic                         in_fire, s_ok, d_ok, better, last_dim;
  logic [CW-1:0]                in_lab;
  logic [CW:0]                  base, cand;
  logic [DW-1:0]                dix, lix;
  logic [NORM_W-1:0]            nn;

  mac_ctl_t                     mac_ctl;
  mac_sts_t                     mac_sts;
  logic signed [ACC_W-1:0]      acc;

  ikr_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (comp_rd),
    .b     (smp_rd),
    .sts   (mac_sts),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (comp_we) comp_mem[comp_wa] <= comp_wd;
    comp_rd <= comp_mem[comp_ra];
  end
  always_ff @(posedge clk) begin
    if (smp_we) smp_mem[smp_wa] <= smp_wd;
    smp_rd <= smp_mem[smp_ra];
  end
  always_ff @(posedge clk) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    lab_rd <= lab_mem[lab_ra];
  end
  always_ff @(posedge clk) begin
    if (norm_we) norm_mem[norm_wa] <= norm_wd;
    norm_rd <= norm_mem[norm_ra];
  end
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cw_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[cw_ra];
  end
  always_ff @(posedge clk) begin
    if (nsum_we) nsum_mem[cw_wa] <= nsum_wd;
    nsum_rd <= nsum_mem[cw_ra];
  end

  always_comb begin
    if (ac_r == '0) begin
      nc = (CW+1)'(1);
    end else if (32'(ac_r) > MAX_CLUSTERS) begin
      nc = (CW+1)'(MAX_CLUSTERS);
    end else begin
      nc = (CW+1)'(ac_r);
    end
    if (ad_r == '0) begin
      nd = (DW+1)'(1);
    end else if (32'(ad_r) > MAX_DIMS) begin
      nd = (DW+1)'(MAX_DIMS);
    end else begin
      nd = (DW+1)'(ad_r);
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && (state_r == S_IDLE);
  assign s_ok         = 32'(in_ch.sample_index) < MAX_SAMPLES;
  assign d_ok         = 32'(in_ch.dim_index) < 32'(nd);
  assign in_lab       = CW'(32'(in_ch.initial_label) % MAX_CLUSTERS);
  assign dix          = dcnt_r[DW-1:0];
  assign lix          = DW'(d_r);
  assign last_dim     = (dcnt_r == nd - (DW+1)'(1));
  assign better       = (prof_r > bestp_r);
  assign nn           = ((d_r == '0) ? '0 : norm_rd) + NORM_W'(sq_r);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.old_label = out_old_r;
  assign out_ch.new_label = out_new_r;
  assign out_ch.moved     = out_mv_r;

  always_comb begin
    state_nxt = state_r;
    s_nxt = s_r; d_nxt = d_r; v_nxt = v_r; lab_nxt = lab_r; sq_nxt = sq_r;
    c_nxt = c_r; first_nxt = first_r; dcnt_nxt = dcnt_r; c0_nxt = c0_r; best_nxt = best_r;
    found_nxt = found_r; norm_nxt = norm_r; cnt_nxt = cnt_r; pl_nxt = pl_r; ph_nxt = ph_r;
    t_nxt = t_r; cost_nxt = cost_r; dista_nxt = dista_r; prof_nxt = prof_r;
    bestp_nxt = bestp_r; x_nxt = x_r; clr_nxt = clr_r;
    rold_nxt = rold_r; rnew_nxt = rnew_r; rmv_nxt = rmv_r;
    out_old_nxt = out_old_r; out_new_nxt = out_new_r; out_mv_nxt = out_mv_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rvld_nxt = 1'b0;
    mac_ctl = '{clr: 1'b0, vld: rvld_r};

    comp_we = 1'b0; comp_wa = {c0_r, dix}; comp_wd = '0; comp_ra = {c_r[CW-1:0], dix};
    smp_we = 1'b0; smp_wa = {s_r, lix}; smp_wd = v_r; smp_ra = {s_r, dix};
    lab_we = 1'b0; lab_wa = s_r; lab_wd = lab_r; lab_ra = s_r;
    norm_we = 1'b0; norm_wa = s_r; norm_wd = nn; norm_ra = s_r;
    cnt_we = 1'b0; nsum_we = 1'b0; cw_wa = lab_r; cw_ra = c_r[CW-1:0];
    cnt_wd = '0; nsum_wd = '0;

    base = '0;
    if (state_r == S_SEL) base = c_r + (CW+1)'(1);
    cand = (base == {1'b0, c0_r}) ? base + (CW+1)'(1) : base;

    case (state_r)
      S_CLR: begin
        comp_we = 1'b1;
        comp_wa = clr_r;
        comp_wd = '0;
        if (clr_r[DW-1:0] == '0) begin
          cnt_we  = 1'b1;
          nsum_we = 1'b1;
          cw_wa   = clr_r[CW+DW-1:DW];
        end
        clr_nxt = clr_r + (CW+DW)'(1);
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          s_nxt   = SW'(in_ch.sample_index);
          d_nxt   = in_ch.dim_index;
          v_nxt   = in_ch.value[DATA_WIDTH-1:0];
          lab_nxt = in_lab;
          rmv_nxt = 1'b0;
          if (in_ch.opcode == OP_LOAD) begin
            rold_nxt  = in_lab;
            rnew_nxt  = in_lab;
            state_nxt = (s_ok && d_ok) ? S_LD0 : S_DONE;
          end else begin
            rold_nxt  = '0;
            rnew_nxt  = '0;
            state_nxt = s_ok ? S_V0 : S_DONE;
          end
        end
      end
      S_LD0: begin
        comp_ra   = {lab_r, lix};
        cw_ra     = lab_r;
        sq_nxt    = SQ_W'(v_r) * SQ_W'(v_r);
        state_nxt = S_LD1;
      end
      S_LD1: begin
        smp_we  = 1'b1;
        lab_we  = 1'b1;
        norm_we = 1'b1;
        comp_we = 1'b1;
        comp_wa = {lab_r, lix};
        comp_wd = comp_rd + COMP_W'(v_r);
        if (32'(d_r) == 32'(nd) - 1) begin
          cnt_we  = 1'b1;
          nsum_we = 1'b1;
          cw_wa   = lab_r;
          cnt_wd  = cnt_rd + CNT_W'(1);
          nsum_wd = nsum_rd + NSUM_W'(nn);
        end
        state_nxt = S_DONE;
      end
      S_V0: begin
        state_nxt = S_V1;
      end
      S_V1: begin
        c0_nxt    = lab_rd;
        norm_nxt  = norm_rd;
        cw_ra     = lab_rd;
        state_nxt = S_V2;
      end
      S_V2: begin
        rold_nxt = c0_r;
        rnew_nxt = c0_r;
        if (cnt_rd == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          first_nxt = 1'b1;
          c_nxt     = {1'b0, c0_r};
          found_nxt = 1'b0;
          best_nxt  = c0_r;
          bestp_nxt = -ACC_W'(1);
          state_nxt = S_CL;
        end
      end
      S_CL: begin
        dcnt_nxt    = '0;
        mac_ctl.clr = 1'b1;
        state_nxt   = S_DOT;
      end
      S_DOT: begin
        rvld_nxt = 1'b1;
        dcnt_nxt = dcnt_r + (DW+1)'(1);
        if (last_dim) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!rvld_r && !mac_sts.busy) state_nxt = S_CNR;
      end
      S_CNR: begin
        state_nxt = S_CN0;
      end
      S_CN0: begin
        cnt_nxt   = cnt_rd;
        pl_nxt    = PL_W'(cnt_rd) * PL_W'(norm_r[NORM_LO_W-1:0]);
        t_nxt     = $signed(ACC_W'(nsum_rd)) - (acc <<< 1);
        state_nxt = S_CN1;
      end
      S_CN1: begin
        ph_nxt    = PH_W'(cnt_r) * PH_W'(norm_r[NORM_W-1:NORM_LO_W]);
        t_nxt     = t_r + $signed(ACC_W'(pl_r));
        state_nxt = S_COST;
      end
      S_COST: begin
        cost_nxt  = t_r + $signed(ACC_W'(ph_r) << NORM_LO_W);
        state_nxt = S_PRF;
      end
      S_PRF: begin
        if (first_r) begin
          dista_nxt = cost_r;
          first_nxt = 1'b0;
          c_nxt     = cand;
          if (cand >= nc) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CL;
          end
        end else begin
          prof_nxt  = dista_r - cost_r;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (better) begin
          bestp_nxt = prof_r;
          best_nxt  = c_r[CW-1:0];
          found_nxt = 1'b1;
        end
        c_nxt = cand;
        if (cand >= nc) begin
          state_nxt = (found_r || better) ? S_MV0 : S_DONE;
        end else begin
          state_nxt = S_CL;
        end
      end
      S_MV0: begin
        lab_we    = 1'b1;
        lab_wd    = best_r;
        cw_ra     = best_r;
        state_nxt = S_MV1;
      end
      S_MV1: begin
        cnt_we    = 1'b1;
        nsum_we   = 1'b1;
        cw_wa     = best_r;
        cnt_wd    = cnt_rd + CNT_W'(1);
        nsum_wd   = nsum_rd + NSUM_W'(norm_r);
        cw_ra     = c0_r;
        state_nxt = S_MV2;
      end
      S_MV2: begin
        cnt_we    = 1'b1;
        nsum_we   = 1'b1;
        cw_wa     = c0_r;
        cnt_wd    = cnt_rd - CNT_W'(1);
        nsum_wd   = nsum_rd - NSUM_W'(norm_r);
        dcnt_nxt  = '0;
        rnew_nxt  = best_r;
        rmv_nxt   = 1'b1;
        state_nxt = S_UA;
      end
      S_UA: begin
        comp_ra   = {c0_r, dix};
        state_nxt = S_UB;
      end
      S_UB: begin
        x_nxt     = smp_rd;
        comp_we   = 1'b1;
        comp_wa   = {c0_r, dix};
        comp_wd   = comp_rd - COMP_W'(smp_rd);
        comp_ra   = {best_r, dix};
        state_nxt = S_UC;
      end
      S_UC: begin
        comp_we = 1'b1;
        comp_wa = {best_r, dix};
        comp_wd = comp_rd + COMP_W'(x_r);
        if (last_dim) begin
          state_nxt = S_DONE;
        end else begin
          dcnt_nxt  = dcnt_r + (DW+1)'(1);
          state_nxt = S_UA;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_old_nxt   = LABEL_W'(rold_r);
          out_new_nxt   = LABEL_W'(rnew_r);
          out_mv_nxt    = rmv_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ac_r        <= NCLU_RESET;
      ad_r        <= NDIM_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_ACTIVE_CLUSTERS) ac_r <= cfg_data[NCLU_CFG_W-1:0];
      if (cfg_we && cfg_index == REG_ACTIVE_DIMS) ad_r <= cfg_data[NDIM_CFG_W-1:0];
    end
    s_r <= s_nxt; d_r <= d_nxt; v_r <= v_nxt; lab_r <= lab_nxt;
    sq_r <= sq_nxt; c_r <= c_nxt; first_r <= first_nxt; dcnt_r <= dcnt_nxt;
    c0_r <= c0_nxt; best_r <= best_nxt; found_r <= found_nxt; norm_r <= norm_nxt;
    cnt_r <= cnt_nxt; pl_r <= pl_nxt; ph_r <= ph_nxt; t_r <= t_nxt; cost_r <= cost_nxt;
    dista_r <= dista_nxt; prof_r <= prof_nxt; bestp_r <= bestp_nxt; x_r <= x_nxt;
    rold_r <= rold_nxt; rnew_r <= rnew_nxt; rmv_r <= rmv_nxt;
    out_old_r <= out_old_nxt; out_new_r <= out_new_nxt; out_mv_r <= out_mv_nxt;
  end
endmodule

// ===== verif/testbench.sv =====
module testbench;
  import ikr_pkg::*;

  localparam int NUM_CLU = 64;
  localparam int NUM_DIM = 128;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 600;

  typedef struct {
    logic [LABEL_W-1:0] old_label;
    logic [LABEL_W-1:0] new_label;
    logic               moved;
  } move_t;

  class move_scoreboard;
    logic signed [VALUE_W-1:0] coord[int];
    logic [LABEL_W-1:0]        label_of[int];
    logic [NORM_W-1:0]         norm_of[int];
    logic signed [COMP_W-1:0]  comp[NUM_CLU*NUM_DIM];
    logic [CNT_W-1:0]          members[NUM_CLU];
    logic [NSUM_W-1:0]         norm_sum[NUM_CLU];
    logic [NCLU_CFG_W-1:0]     n_clusters;
    logic [NDIM_CFG_W-1:0]     n_dims;
    move_t                     pending[$];
    int                        errors;

    function new();
      foreach (comp[i]) comp[i] = '0;
      foreach (members[i]) members[i] = '0;
      foreach (norm_sum[i]) norm_sum[i] = '0;
      n_clusters = NCLU_RESET;
      n_dims = NDIM_RESET;
      errors = 0;
    endfunction

    function int eff_clusters();
      if (n_clusters == 0) return 1;
      if (n_clusters > NUM_CLU) return NUM_CLU;
      return int'(n_clusters);
    endfunction

    function int eff_dims();
      if (n_dims == 0) return 1;
      if (n_dims > NUM_DIM) return NUM_DIM;
      return int'(n_dims);
    endfunction

    function longint cluster_cost(int c, int s, int nd);
      longint dot;
      dot = 0;
      for (int d = 0; d < nd; d++)
        dot += longint'(comp[c*NUM_DIM+d]) * longint'(coord[s*NUM_DIM+d]);
      return longint'({14'b0, norm_sum[c]}) - 2 * dot
             + longint'({51'b0, members[c]}) * longint'({26'b0, norm_of[s]});
    endfunction

    function void note(logic op, logic [SIDX_W-1:0] s, logic [DIDX_W-1:0] d,
                       logic signed [VALUE_W-1:0] v, logic [LABEL_W-1:0] l);
      int nd, nc, c0, best;
      longint base, profit, best_profit;
      longint sq;
      move_t m;
      nd = eff_dims();
      if (op == OP_LOAD) begin
        m = '{l, l, 1'b0};
        if (int'(d) < nd) begin
          coord[s*NUM_DIM+d] = v;
          label_of[s] = l;
          comp[l*NUM_DIM+d] = comp[l*NUM_DIM+d] + {{(COMP_W-VALUE_W){v[VALUE_W-1]}}, v};
          sq = longint'(v) * longint'(v);
          norm_of[s] = ((d == 0) ? '0 : norm_of[s]) + sq[NORM_W-1:0];
          if (int'(d) == nd - 1) begin
            members[l] = members[l] + 1'b1;
            norm_sum[l] = norm_sum[l] + norm_of[s];
          end
        end
        pending.insert(pending.size(), m);
        return;
      end
      c0 = label_of[s];
      m = '{c0[LABEL_W-1:0], c0[LABEL_W-1:0], 1'b0};
      if (members[c0] != 1) begin
        nc = eff_clusters();
        base = cluster_cost(c0, s, nd);
        best = -1;
        best_profit = -1;
        for (int c = 0; c < nc; c++) begin
          if (c == c0) continue;
          profit = base - cluster_cost(c, s, nd);
          if (profit > best_profit) begin
            best_profit = profit;
            best = c;
          end
        end
        if (best >= 0) begin
          label_of[s] = best[LABEL_W-1:0];
          members[best] = members[best] + 1'b1;
          members[c0] = members[c0] - 1'b1;
          norm_sum[best] = norm_sum[best] + norm_of[s];
          norm_sum[c0] = norm_sum[c0] - norm_of[s];
          for (int d2 = 0; d2 < nd; d2++) begin
            comp[c0*NUM_DIM+d2] = comp[c0*NUM_DIM+d2]
              - {{(COMP_W-VALUE_W){coord[s*NUM_DIM+d2][VALUE_W-1]}}, coord[s*NUM_DIM+d2]};
            comp[best*NUM_DIM+d2] = comp[best*NUM_DIM+d2]
              + {{(COMP_W-VALUE_W){coord[s*NUM_DIM+d2][VALUE_W-1]}}, coord[s*NUM_DIM+d2]};
          end
          m.new_label = best[LABEL_W-1:0];
          m.moved = 1'b1;
        end
      end
      pending.insert(pending.size(), m);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(logic [LABEL_W-1:0] o, logic [LABEL_W-1:0] n, logic mv);
      move_t m;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result old=%0d new=%0d moved=%0b", o, n, mv));
        return;
      end
      m = pending.pop_front();
      if (o !== m.old_label)
        report($sformatf("old_label got %0d want %0d", o, m.old_label));
      if (n !== m.new_label)
        report($sformatf("new_label got %0d want %0d", n, m.new_label));
      if (mv !== m.moved)
        report($sformatf("moved got %0b want %0b", mv, m.moved));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ikr_in_if in_ch();
  ikr_out_if out_ch();

  incremental_kmeans_refine DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  move_scoreboard sb = new();
  bit quiet;
  int hold_len;
  int hold_req;
  int random_items;
  int cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note(in_ch.opcode, in_ch.sample_index, in_ch.dim_index, in_ch.value,
              in_ch.initial_label);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check(out_ch.old_label, out_ch.new_label, out_ch.moved);
  end

  initial begin
    int w;
    int holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 13);
      if (hold_req != holds_done) begin
        w = hold_len;
        holds_done = hold_req;
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task send(logic op, int s, int d, int v, int l);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.sample_index <= s[SIDX_W-1:0];
    in_ch.dim_index <= d[DIDX_W-1:0];
    in_ch.value <= v[VALUE_W-1:0];
    in_ch.initial_label <= l[LABEL_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task set_cfg(int nc, int nd);
    cfg_we <= 1'b1;
    cfg_index <= REG_ACTIVE_CLUSTERS;
    cfg_data <= nc[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_ACTIVE_DIMS;
    cfg_data <= nd[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.n_clusters = nc[NCLU_CFG_W-1:0];
    sb.n_dims = nd[NDIM_CFG_W-1:0];
  endtask

  task run_phase(int nc, int nd, bit calm, int hold, int nsamp);
    int samples[$];
    int s, l, ncef, ndef, nvis, xd;
    drain();
    set_cfg(nc, nd);
    ncef = (nc[6:0] == 0) ? 1 : ((nc[6:0] > NUM_CLU) ? NUM_CLU : nc[6:0]);
    ndef = (nd[7:0] == 0) ? 1 : ((nd[7:0] > NUM_DIM) ? NUM_DIM : nd[7:0]);
    quiet = calm;
    hold_len = hold;
    if (hold > 0) hold_req++;
    if (nsamp == 0) nsamp = $urandom_range(2, 6);
    for (int i = 0; i < nsamp; i++) begin
      s = $urandom_range(0, 4095);
      l = $urandom_range(0, (ncef < 63) ? ncef : 63);
      if ($urandom_range(0, 9) == 0) l = $urandom_range(0, 63);
      for (int d = 0; d < ndef; d++) begin
        send(OP_LOAD, s, d, $urandom, l);
        random_items++;
        if ($urandom_range(0, 9) == 0) begin
          xd = (ndef >= NUM_DIM || $urandom_range(0, 1) == 0) ? 0
               : $urandom_range(ndef, 127);
          send(OP_LOAD, $urandom_range(0, 4095), xd, $urandom, $urandom_range(0, 63));
          random_items++;
        end
      end
      samples.insert(samples.size(), s);
    end
    nvis = $urandom_range(3, 8);
    for (int i = 0; i < nvis; i++) begin
      send(OP_VISIT, samples[$urandom_range(0, samples.size() - 1)], $urandom, $urandom,
           $urandom);
      random_items++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    int nc, nd, r;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_ACTIVE_CLUSTERS;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_LOAD;
    in_ch.sample_index <= '0;
    in_ch.dim_index <= '0;
    in_ch.value <= '0;
    in_ch.initial_label <= '0;
    quiet = 1'b0;
    hold_len = 0;
    hold_req = 0;
    random_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_cfg(4, 2);
    send(OP_LOAD, 0, 0, 32767, 0);
    send(OP_LOAD, 0, 1, -32768, 0);
    send(OP_LOAD, 1, 0, -32768, 0);
    send(OP_LOAD, 1, 1, 32767, 0);
    send(OP_LOAD, 4095, 0, -1, 63);
    send(OP_LOAD, 4095, 1, 0, 63);
    send(OP_LOAD, 5, 127, 7, 5);
    send(OP_LOAD, 2, 0, 1, 1);
    send(OP_LOAD, 2, 1, 1, 1);
    send(OP_LOAD, 3, 0, 5, 0);
    send(OP_LOAD, 3, 1, 5, 0);
    send(OP_LOAD, 6, 0, 5, 0);
    send(OP_LOAD, 6, 1, 5, 0);
    send(OP_VISIT, 0, 0, 0, 0);
    send(OP_VISIT, 4095, 0, 0, 0);
    send(OP_VISIT, 2, 0, 0, 0);
    send(OP_VISIT, 3, 0, 0, 0);
    send(OP_VISIT, 1, 0, 0, 0);
    drain();
    set_cfg(0, 0);
    send(OP_VISIT, 1, 0, 0, 0);
    send(OP_VISIT, 6, 0, 0, 0);
    send(OP_LOAD, 7, 0, 9, 3);
    send(OP_LOAD, 7, 1, 9, 3);
    send(OP_VISIT, 7, 0, 0, 0);
    drain();
    set_cfg(4, 255);
    send(OP_LOAD, 3, 126, 13, 0);
    send(OP_LOAD, 3, 127, 11, 0);

    run_phase(127, 3, 1'b0, 0, 2);
    run_phase(6, 6, 1'b1, 300, 6);
    while (random_items < 75) begin
      r = $urandom_range(0, 9);
      nc = (r == 0) ? 0 : ((r == 1) ? 127 : $urandom_range(2, 8));
      nd = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      run_phase(nc, nd, $urandom_range(0, 3) == 0, 0, 0);
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
